### design/ihp_pkg.sv
// Shared constants, codes and types of the indexed max-heap core.
// Used by the channel interfaces, the memories, the core and its checker.
package ihp_pkg;

  localparam int CAPACITY    = 1024;
  localparam int KEY_BITS    = 32;
  localparam int ID_SPACE    = 1024;
  localparam int ID_BITS     = $clog2(ID_SPACE);
  localparam int SLOT_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]         id;
  } slot_entry_t;

  typedef struct packed {
    logic                 present;
    logic [SLOT_BITS-1:0] pos;
  } pos_entry_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    slot_entry_t          wdata;
    logic                 re;
    logic [SLOT_BITS-1:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic               we;
    logic [ID_BITS-1:0] waddr;
    pos_entry_t         wdata;
    logic               re;
    logic [ID_BITS-1:0] raddr;
  } pos_req_t;

endpackage

### design/ihp_if.sv
// Request and response channel interfaces of the indexed max-heap core.
// Depends on ihp_pkg for field widths.
interface ihp_req_if;
  import ihp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [ID_BITS-1:0]         item_id;
  logic signed [KEY_BITS-1:0] key_value;
  modport source(output valid, req_type, item_id, key_value, input ready);
  modport sink(input valid, req_type, item_id, key_value, output ready);
endinterface

interface ihp_rsp_if;
  import ihp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic signed [KEY_BITS-1:0] top_key;
  logic [ID_BITS-1:0]         top_id;
  logic                       heap_empty;
  logic [COUNT_BITS-1:0]      entry_count;
  modport source(output valid, status, top_key, top_id, heap_empty, entry_count,
                 input ready);
  modport sink(input valid, status, top_key, top_id, heap_empty, entry_count,
               output ready);
endinterface

### design/ihp_slot_ram.sv
// Heap slot memory: key and id per slot, one write and one registered read.
// Depends on ihp_pkg.
module ihp_slot_ram (
  input  logic               clk,
  input  ihp_pkg::slot_req_t req,
  output ihp_pkg::slot_entry_t rdata
);
  import ihp_pkg::*;

  slot_entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### design/ihp_pos_ram.sv
// Id position table: present flag and heap slot per id, registered read.
// Depends on ihp_pkg.
module ihp_pos_ram (
  input  logic              clk,
  input  ihp_pkg::pos_req_t req,
  output ihp_pkg::pos_entry_t rdata
);
  import ihp_pkg::*;

  pos_entry_t mem [ID_SPACE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### design/indexed_max_heap_core.sv
// Indexed max-heap core: sequencer, key comparators and response register.
// Depends on ihp_pkg, ihp_if, ihp_slot_ram and ihp_pos_ram.
//
//   channel | dir | transaction
//   req     | in  | req_type, item_id, key_value
//   rsp     | out | status, top_key, top_id, heap_empty, entry_count
//
// After acceptance an insert climbs from the new last slot; a delete fills the
// freed slot with the last entry, which then climbs or, if it does not rise,
// descends; deleting the last slot needs neither.
// Each level up is a parent read followed by a compare-and-write;
// a level down reads both children through the single read port, then compares.
// The core passes through S_IDLE before it takes the next request; the response stage stalls while
// the previous response is unread. req is taken again while a response waits on rsp.
// After reset a clearing pass empties every entry of the id table; req.ready
// stays low meanwhile.
module indexed_max_heap_core (
  input logic clk,
  input logic rst,
  ihp_req_if.sink   req,
  ihp_rsp_if.source rsp
);
  import ihp_pkg::*;

  localparam int WIDE_BITS = SLOT_BITS + 2;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_CHECK  = 11'b00000000100,
    S_DEL    = 11'b00000001000,
    S_UP_RD  = 11'b00000010000,
    S_UP_CMP = 11'b00000100000,
    S_DN_RL  = 11'b00001000000,
    S_DN_RR  = 11'b00010000000,
    S_DN_CMP = 11'b00100000000,
    S_TOP_RD = 11'b01000000000,
    S_TOP    = 11'b10000000000
  } state_t;

  state_t                state, state_next;
  logic [ID_BITS-1:0]    clr_idx, clr_idx_next;
  logic [COUNT_BITS-1:0] count, count_next;

  req_kind_t             kind;
  logic [ID_BITS-1:0]    req_id;
  logic signed [KEY_BITS-1:0] req_key;

  slot_entry_t           held, held_next;
  slot_entry_t           child, child_next;
  logic [SLOT_BITS-1:0]  cur, cur_next;
  logic                  moved, moved_next;
  logic                  right_ok, right_ok_next;
  status_t               status, status_next;

  logic                  rsp_valid;
  status_t               rsp_status;
  logic signed [KEY_BITS-1:0] rsp_key;
  logic [ID_BITS-1:0]    rsp_id;
  logic                  rsp_empty;
  logic [COUNT_BITS-1:0] rsp_count;
  logic                  load_rsp;

  slot_req_t             slot_req;
  slot_entry_t           slot_rdata;
  pos_req_t              pos_req;
  pos_entry_t            pos_rdata;

  logic                  place;
  logic [COUNT_BITS-1:0] last;
  logic [SLOT_BITS-1:0]  cur_m1;
  logic [SLOT_BITS-1:0]  parent;
  logic [WIDE_BITS-1:0]  left_w;
  logic [WIDE_BITS-1:0]  right_w;
  logic [WIDE_BITS-1:0]  count_w;
  logic                  pick_right;
  slot_entry_t           pick;
  logic [SLOT_BITS-1:0]  pick_pos;

  ihp_slot_ram u_slot_ram (.clk(clk), .req(slot_req), .rdata(slot_rdata));
  ihp_pos_ram  u_pos_ram  (.clk(clk), .req(pos_req),  .rdata(pos_rdata));

  assign last    = count - 1'b1;
  assign cur_m1  = cur - 1'b1;
  assign parent  = {1'b0, cur_m1[SLOT_BITS-1:1]};
  assign left_w  = {1'b0, cur, 1'b1};
  assign right_w = left_w + 1'b1;
  assign count_w = {{(WIDE_BITS-COUNT_BITS){1'b0}}, count};

  assign pick_right = right_ok && ($signed(slot_rdata.key) >= $signed(child.key));
  assign pick       = pick_right ? slot_rdata : child;
  assign pick_pos   = pick_right ? right_w[SLOT_BITS-1:0] : left_w[SLOT_BITS-1:0];

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.top_key     = rsp_key;
  assign rsp.top_id      = rsp_id;
  assign rsp.heap_empty  = rsp_empty;
  assign rsp.entry_count = rsp_count;

  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    count_next    = count;
    held_next     = held;
    child_next    = child;
    cur_next      = cur;
    moved_next    = moved;
    right_ok_next = right_ok;
    status_next   = status;
    slot_req      = '0;
    pos_req       = '0;
    place         = 1'b0;
    load_rsp      = 1'b0;

    case (state)
      S_CLEAR: begin
        pos_req.we    = 1'b1;
        pos_req.waddr = clr_idx;
        pos_req.wdata = '0;
        clr_idx_next  = clr_idx + 1'b1;
        if (clr_idx == ID_BITS'(ID_SPACE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        pos_req.re    = 1'b1;
        pos_req.raddr = req.item_id;
        if (req.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        moved_next = 1'b0;
        if (kind == REQ_INSERT) begin
          if (pos_rdata.present) begin
            status_next = ST_PRESENT;
            state_next  = S_TOP_RD;
          end else if (count == COUNT_BITS'(CAPACITY)) begin
            status_next = ST_FULL;
            state_next  = S_TOP_RD;
          end else begin
            status_next  = ST_OK;
            held_next.key = req_key;
            held_next.id  = req_id;
            cur_next     = count[SLOT_BITS-1:0];
            count_next   = count + 1'b1;
            state_next   = S_UP_RD;
          end
        end else begin
          if (!pos_rdata.present || count == '0) begin
            status_next = ST_ABSENT;
            state_next  = S_TOP_RD;
          end else begin
            status_next    = ST_OK;
            cur_next       = (COUNT_BITS'(pos_rdata.pos) > last) ?
                             last[SLOT_BITS-1:0] : pos_rdata.pos;
            slot_req.re    = 1'b1;
            slot_req.raddr = last[SLOT_BITS-1:0];
            state_next     = S_DEL;
          end
        end
      end
      S_DEL: begin
        held_next     = slot_rdata;
        pos_req.we    = 1'b1;
        pos_req.waddr = req_id;
        pos_req.wdata = '0;
        count_next    = last;
        if (COUNT_BITS'(cur) == last) begin
          state_next = S_TOP_RD;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (cur == '0) begin
          if (kind == REQ_INSERT || moved) begin
            place      = 1'b1;
            state_next = S_TOP_RD;
          end else begin
            state_next = S_DN_RL;
          end
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = parent;
          state_next     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if ($signed(held.key) > $signed(slot_rdata.key)) begin
          slot_req.we   = 1'b1;
          slot_req.waddr = cur;
          slot_req.wdata = slot_rdata;
          pos_req.we    = 1'b1;
          pos_req.waddr = slot_rdata.id;
          pos_req.wdata = '{present: 1'b1, pos: cur};
          cur_next      = parent;
          moved_next    = 1'b1;
          state_next    = S_UP_RD;
        end else if (kind == REQ_INSERT || moved) begin
          place      = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          state_next = S_DN_RL;
        end
      end
      S_DN_RL: begin
        if (left_w >= count_w) begin
          place      = 1'b1;
          state_next = S_TOP_RD;
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = left_w[SLOT_BITS-1:0];
          state_next     = S_DN_RR;
        end
      end
      S_DN_RR: begin
        child_next    = slot_rdata;
        right_ok_next = (right_w < count_w);
        if (right_w < count_w) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = right_w[SLOT_BITS-1:0];
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if ($signed(pick.key) > $signed(held.key)) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = cur;
          slot_req.wdata = pick;
          pos_req.we     = 1'b1;
          pos_req.waddr  = pick.id;
          pos_req.wdata  = '{present: 1'b1, pos: cur};
          cur_next       = pick_pos;
          state_next     = S_DN_RL;
        end else begin
          place      = 1'b1;
          state_next = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        slot_req.re    = 1'b1;
        slot_req.raddr = '0;
        state_next     = S_TOP;
      end
      S_TOP: begin
        if (!rsp_valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (place) begin
      slot_req.we    = 1'b1;
      slot_req.waddr = cur;
      slot_req.wdata = held;
      pos_req.we     = 1'b1;
      pos_req.waddr  = held.id;
      pos_req.wdata  = '{present: 1'b1, pos: cur};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held     <= held_next;
    child    <= child_next;
    cur      <= cur_next;
    moved    <= moved_next;
    right_ok <= right_ok_next;
    status   <= status_next;
    if (req.valid && req.ready) begin
      kind    <= req_kind_t'(req.req_type);
      req_id  <= req.item_id;
      req_key <= req.key_value;
    end
    if (load_rsp) begin
      rsp_status <= status;
      rsp_empty  <= (count == '0);
      rsp_count  <= count;
      if (count != '0) begin
        rsp_key <= slot_rdata.key;
        rsp_id  <= slot_rdata.id;
      end else begin
        rsp_key <= '0;
        rsp_id  <= '0;
      end
    end
  end

endmodule

### design/ihp_checker.sv
// Port-level checks of the indexed max-heap core, bound to its top level.
// Depends on ihp_pkg and indexed_max_heap_core.
module ihp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [ihp_pkg::STATUS_BITS-1:0]     status,
  input logic signed [ihp_pkg::KEY_BITS-1:0] top_key,
  input logic [ihp_pkg::ID_BITS-1:0]         top_id,
  input logic                                heap_empty,
  input logic [ihp_pkg::COUNT_BITS-1:0]      entry_count
);
  import ihp_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(top_key))
    else $error("response changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (heap_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && heap_empty |-> (top_key == '0) && (top_id == '0))
    else $error("top entry not zero on empty heap");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= COUNT_BITS'(CAPACITY)))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (entry_count == COUNT_BITS'(CAPACITY)))
    else $error("full status with room left");

endmodule

bind indexed_max_heap_core ihp_checker u_ihp_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .status(rsp.status),
  .top_key(rsp.top_key),
  .top_id(rsp.top_id),
  .heap_empty(rsp.heap_empty),
  .entry_count(rsp.entry_count)
);

### bench/tb_indexed_max_heap_core.sv
`timescale 1ns / 100ps
// Self-checking bench for indexed_max_heap_core: directed, random, back-pressure and fill tests.
// Depends on ihp_pkg and the ihp_req_if / ihp_rsp_if channel interfaces.
module tb_indexed_max_heap_core;
  import ihp_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 96;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [ID_BITS-1:0]         id_t;

  typedef struct {
    status_t               status;
    key_t                  top_key;
    id_t                   top_id;
    logic                  heap_empty;
    logic [COUNT_BITS-1:0] entry_count;
  } heap_rsp_t;

  logic clk;
  logic rst;

  ihp_req_if req_if ();
  ihp_rsp_if rsp_if ();

  indexed_max_heap_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // mirror of the heap
  key_t heap_key [CAPACITY];
  id_t  heap_id  [CAPACITY];
  int   id_slot  [ID_SPACE];
  bit   id_held  [ID_SPACE];
  int   heap_count;

  heap_rsp_t pending_rsp[$];

  int  errors;
  int  sent_cnt;
  int  checked_cnt;
  int  status_seen [4];
  int  peak_count;
  bit  send_gaps;
  int  burst_left;
  int  rsp_mode;
  bit  hold_start;
  int  hold_left;
  logic [7:0] rsp_pattern;
  int  pattern_age;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("indexed_max_heap_core test failed");
    $finish;
  end

  function automatic void swap_slots(int a, int b);
    key_t k;
    id_t  d;
    k = heap_key[a];
    d = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a]  = heap_id[b];
    heap_key[b] = k;
    heap_id[b]  = d;
    id_slot[heap_id[a]] = a;
    id_slot[heap_id[b]] = b;
  endfunction

  function automatic void sift_up(int p);
    int parent;
    while (p > 0) begin
      parent = (p - 1) / 2;
      if (heap_key[p] <= heap_key[parent]) break;
      swap_slots(p, parent);
      p = parent;
    end
  endfunction

  function automatic void sift_down(int p);
    int left;
    int pick;
    while (1) begin
      left = 2 * p + 1;
      if (left >= heap_count) break;
      pick = left;
      if (left + 1 < heap_count && heap_key[left + 1] >= heap_key[left]) pick = left + 1;
      if (heap_key[pick] <= heap_key[p]) break;
      swap_slots(p, pick);
      p = pick;
    end
  endfunction

  function automatic heap_rsp_t apply_request(req_kind_t kind, id_t id, key_t key);
    heap_rsp_t r;
    int p;
    int last;
    r.status = ST_OK;
    if (kind == REQ_INSERT) begin
      if (id_held[id]) begin
        r.status = ST_PRESENT;
      end else if (heap_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_key[heap_count] = key;
        heap_id[heap_count]  = id;
        id_slot[id] = heap_count;
        id_held[id] = 1'b1;
        heap_count++;
        sift_up(heap_count - 1);
      end
    end else begin
      if (!id_held[id] || heap_count == 0) begin
        r.status = ST_ABSENT;
      end else begin
        p = id_slot[id];
        last = heap_count - 1;
        swap_slots(p, last);
        id_held[id] = 1'b0;
        heap_count = last;
        if (p < heap_count) begin
          sift_up(p);
          sift_down(p);
        end
      end
    end
    if (heap_count > 0) begin
      r.top_key    = heap_key[0];
      r.top_id     = heap_id[0];
      r.heap_empty = 1'b0;
    end else begin
      r.top_key    = '0;
      r.top_id     = '0;
      r.heap_empty = 1'b1;
    end
    r.entry_count = heap_count[COUNT_BITS-1:0];
    return r;
  endfunction

  // drive one transaction at a falling edge, hold until taken, then idle per burst state
  task automatic send_req(req_kind_t kind, id_t id, key_t key);
    int gap;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.item_id   <= id;
    req_if.key_value <= key;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    pending_rsp.push_back(apply_request(kind, id, key));
    sent_cnt++;
    if (heap_count > peak_count) peak_count = heap_count;
    @(negedge clk);
    if (send_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() > 0) @(negedge clk);
  endtask

  function automatic key_t random_key();
    case ($urandom_range(0, 9))
      5, 6, 7: return key_t'($signed($urandom_range(0, 8)) - 4);
      8:       return {1'b0, {(KEY_BITS-1){1'b1}}} - key_t'($urandom_range(0, 2));
      9:       return {1'b1, {(KEY_BITS-1){1'b0}}} + key_t'($urandom_range(0, 2));
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic id_t absent_id();
    int start;
    start = $urandom_range(0, ID_SPACE - 1);
    for (int i = 0; i < ID_SPACE; i++) begin
      if (!id_held[(start + i) % ID_SPACE]) return id_t'((start + i) % ID_SPACE);
    end
    return id_t'(start);
  endfunction

  task automatic send_random(int insert_pct);
    if ($urandom_range(0, 99) < 12) begin
      send_req(req_kind_t'($urandom_range(0, 1)), id_t'($urandom_range(0, ID_SPACE - 1)),
               random_key());
    end else if (heap_count == 0 ||
                 (heap_count < CAPACITY && $urandom_range(0, 99) < insert_pct)) begin
      send_req(REQ_INSERT, absent_id(), random_key());
    end else begin
      send_req(REQ_DELETE, heap_id[$urandom_range(0, heap_count - 1)], '0);
    end
  endtask

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      rsp_pattern = 8'($urandom) | 8'h01;
      pattern_age = $urandom_range(40, 120);
    end else begin
      rsp_pattern = {rsp_pattern[6:0], rsp_pattern[7]};
      pattern_age--;
    end
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      case (rsp_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 99) < 70);
        default: rsp_if.ready <= rsp_pattern[0];
      endcase
    end
  end

  always @(posedge clk) begin
    heap_rsp_t exp;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response transaction: status %0d count %0d", rsp_if.status,
               rsp_if.entry_count);
        errors++;
      end else begin
        exp = pending_rsp.pop_front();
        checked_cnt++;
        status_seen[exp.status]++;
        if (rsp_if.status !== exp.status) begin
          $error("status: expected %0d actual %0d", exp.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.top_key !== exp.top_key) begin
          $error("top_key: expected %0d actual %0d", exp.top_key, rsp_if.top_key);
          errors++;
        end
        if (rsp_if.top_id !== exp.top_id) begin
          $error("top_id: expected %0d actual %0d", exp.top_id, rsp_if.top_id);
          errors++;
        end
        if (rsp_if.heap_empty !== exp.heap_empty) begin
          $error("heap_empty: expected %0d actual %0d", exp.heap_empty, rsp_if.heap_empty);
          errors++;
        end
        if (rsp_if.entry_count !== exp.entry_count) begin
          $error("entry_count: expected %0d actual %0d", exp.entry_count,
                 rsp_if.entry_count);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    key_t kmax;
    key_t kmin;
    kmax = {1'b0, {(KEY_BITS-1){1'b1}}};
    kmin = {1'b1, {(KEY_BITS-1){1'b0}}};
    send_gaps = 1'b1;
    rsp_mode  = 1;
    send_req(REQ_DELETE, 10'd5, '0);
    send_req(REQ_INSERT, 10'd0, kmin);
    send_req(REQ_INSERT, 10'd1023, kmax);
    send_req(REQ_INSERT, 10'd0, 32'sd3);
    send_req(REQ_INSERT, 10'd7, kmax);
    send_req(REQ_DELETE, 10'd1023, '1);
    send_req(REQ_DELETE, 10'd7, '0);
    send_req(REQ_DELETE, 10'd0, '0);
    send_req(REQ_DELETE, 10'd0, '0);
    // equal children below a moved root: right child rises
    send_req(REQ_INSERT, 10'd20, 32'sd50);
    send_req(REQ_INSERT, 10'd21, 32'sd40);
    send_req(REQ_INSERT, 10'd22, 32'sd40);
    send_req(REQ_INSERT, 10'd23, 32'sd10);
    send_req(REQ_DELETE, 10'd20, '0);
    send_req(REQ_DELETE, 10'd21, '0);
    send_req(REQ_DELETE, 10'd22, '0);
    send_req(REQ_DELETE, 10'd23, '0);
    // delete deep in one subtree, last entry from the other climbs
    send_req(REQ_INSERT, 10'd30, 32'sd100);
    send_req(REQ_INSERT, 10'd31, 32'sd10);
    send_req(REQ_INSERT, 10'd32, 32'sd90);
    send_req(REQ_INSERT, 10'd33, 32'sd5);
    send_req(REQ_INSERT, 10'd34, 32'sd6);
    send_req(REQ_INSERT, 10'd35, 32'sd80);
    send_req(REQ_DELETE, 10'd33, '0);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int insert_pct);
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        rsp_mode  = $urandom_range(0, 2);
      end
      send_random(insert_pct);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_gaps  = 1'b0;
    rsp_mode   = 0;
    hold_start = 1'b1;
    for (int i = 0; i < 40; i++) send_random(60);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    id_t victim;
    send_gaps = 1'b1;
    rsp_mode  = 2;
    while (heap_count < CAPACITY) send_req(REQ_INSERT, absent_id(), random_key());
    // with every id held, insert at capacity reports the present id first
    send_req(REQ_INSERT, id_t'($urandom_range(0, ID_SPACE - 1)), random_key());
    victim = heap_id[$urandom_range(0, CAPACITY - 1)];
    send_req(REQ_DELETE, victim, '0);
    send_req(REQ_INSERT, victim, random_key());
    send_req(REQ_DELETE, heap_id[0], '0);
    send_req(REQ_DELETE, heap_id[CAPACITY - 2], '0);
    wait_drained();
  endtask

  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_INSERT;
    req_if.item_id   = '0;
    req_if.key_value = '0;
    rsp_if.ready     = 1'b0;
    errors      = 0;
    sent_cnt    = 0;
    checked_cnt = 0;
    peak_count  = 0;
    heap_count  = 0;
    send_gaps   = 1'b0;
    burst_left  = 0;
    rsp_mode    = 0;
    hold_start  = 1'b0;
    hold_left   = 0;
    rsp_pattern = 8'hff;
    pattern_age = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(150, 70);
    test_backpressure();
    test_fill_to_capacity();
    test_random(80, 35);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      errors++;
    end
    $display("Run: %0d requests sent, %0d responses checked, peak occupancy %0d of %0d",
             sent_cnt, checked_cnt, peak_count, CAPACITY);
    $display("Status mix: ok %0d, full %0d, present %0d, absent %0d; %0d errors",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_PRESENT],
             status_seen[ST_ABSENT], errors);
    if (errors == 0) begin
      $display("indexed_max_heap_core test passed");
    end else begin
      $display("indexed_max_heap_core test failed");
    end
    $finish;
  end

endmodule
